[hdl/assert_macros.svh]
// Assertion helpers used by the RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/jep_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jep_pkg;

   // Marker bytes
   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_SOS    = 8'hDA;
   localparam logic [7:0] MARKER_EOI    = 8'hD9;
   localparam logic [7:0] MARKER_APP1   = 8'hE1;

   // TIFF / Exif constants
   localparam logic [7:0]  CHAR_I          = 8'h49;
   localparam logic [7:0]  CHAR_M          = 8'h4D;
   localparam logic [15:0] TIFF_MAGIC      = 16'd42;
   localparam logic [15:0] TAG_ORIENTATION = 16'h0112;
   localparam logic [15:0] TYPE_SHORT      = 16'd3;
   localparam logic [3:0]  ENTRY_LAST_IDX  = 4'd11;   // 12-byte entries
   localparam logic [3:0]  ORIENT_DEFAULT  = 4'd1;
   localparam logic [15:0] TIFF_MIN_LEN    = 16'd8;
   localparam logic [15:0] EXIF_HDR_LEN    = 16'd6;

   // Parser phases
   typedef enum logic [3:0] {
      PH_SOI0    = 4'd0,
      PH_SOI1    = 4'd1,
      PH_MARK0   = 4'd2,
      PH_MARK1   = 4'd3,
      PH_LEN0    = 4'd4,
      PH_LEN1    = 4'd5,
      PH_SKIP    = 4'd6,
      PH_EXIFHDR = 4'd7,
      PH_TIFFHDR = 4'd8,
      PH_GAP     = 4'd9,
      PH_COUNT   = 4'd10,
      PH_ENTRY   = 4'd11,
      PH_VALUE   = 4'd12,
      PH_WAIT    = 4'd13,
      PH_DONE    = 4'd14
   } phase_type;

   // One input word as it travels from the input stage to the parser
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   // "Exif\0\0" signature byte by position
   function automatic logic [7:0] exif_sig(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h45;
         3'd1:    ch = 8'h78;
         3'd2:    ch = 8'h69;
         3'd3:    ch = 8'h66;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[hdl/jpeg_exif_orientation_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// JPEG Exif orientation parser. Feed the file one byte per word on the req_
// channel, with req_last_byte set on the final byte; exactly one rsp_ word
// comes back per buffer, carrying the orientation code 1..8 (1 when the tag
// is absent, the file is malformed or the Exif segment is cut short). The
// block takes one byte every cycle while no last byte waits: each byte
// moves the segment walker one step between the input register and the
// result register, which takes the answer when the last byte steps.
// Only a last byte waits on the result register; other bytes flow even while
// a result is still pending. After the last byte the parser is back at its
// start, so the next byte begins a new buffer.
module jpeg_exif_orientation_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_orientation
);
   import jep_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       out_space;
   logic       step;
   logic [3:0] answer;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] orient_ff, orient_in;

   // a last byte needs a free result register, other bytes never wait
   assign out_space = !rsp_valid_ff || rsp_ready;
   assign step      = item_valid && (!item.last_byte || out_space);

   jep_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .take          (step),
      .item_valid    (item_valid),
      .item          (item)
   );

   jep_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .answer (answer)
   );

   // result register
   always_comb begin
      rsp_valid_in = (step && item.last_byte) || (rsp_valid_ff && !rsp_ready);
      orient_in    = (step && item.last_byte) ? answer : orient_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      orient_ff <= orient_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_orientation = orient_ff;

   // checks
   `ASSERT_IMPLIES(a_orient_range, clock, reset, rsp_valid_ff,
      orient_ff >= 4'd1 && orient_ff <= 4'd8, "orientation out of range")
   `ASSERT_NEXT(a_last_held, clock, reset, item_valid && item.last_byte && !out_space,
      item_valid && item.last_byte, "last byte dropped while result pending")
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(step && item.last_byte), "result without a last byte")

endmodule

`default_nettype wire

[hdl/jep_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module jep_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   input  wire logic              take,
   output logic                   item_valid,
   output jep_pkg::item_type      item
);
   import jep_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // room when nothing is held or the held word leaves this cycle
   assign req_ready = !hold_valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hold_valid_in = accept || (hold_valid_ff && !take);
      item_in       = item_ff;
      if (accept) begin
         item_in.data_byte = req_data_byte;
         item_in.last_byte = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = hold_valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[hdl/jep_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module jep_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire jep_pkg::item_type item,
   output logic [3:0]             answer
);
   import jep_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] gather_ff, gather_in;
   logic [3:0]  gcnt_ff, gcnt_in;
   logic [15:0] seg_rem_ff, seg_rem_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] tiff_pos_ff, tiff_pos_in;
   logic [15:0] tiff_len_ff, tiff_len_in;
   logic        le_ff, le_in;
   logic [15:0] dir_ff, dir_in;
   logic [15:0] entries_ff, entries_in;
   logic [31:0] tag_type_ff, tag_type_in;
   logic [3:0]  pend_ff, pend_in;

   // byte-order helpers
   function automatic logic [15:0] order16(input logic [15:0] raw, input logic le);
      return le ? {raw[7:0], raw[15:8]} : raw;
   endfunction

   function automatic logic [31:0] order32(input logic [31:0] raw, input logic le);
      return le ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
   endfunction

   logic [7:0]  b;
   logic [31:0] shifted;
   logic [15:0] rem_dec;
   logic [15:0] len_word, len_rem;
   logic [15:0] skip_rem;
   logic [31:0] off32;
   logic [15:0] gap_pos;
   logic [15:0] cnt_word;
   logic [19:0] need;
   logic [15:0] avail;
   logic [15:0] ent_dec;
   logic [15:0] val_word;
   logic        fix_en;
   logic [3:0]  fix_val;
   logic        done_c;
   logic [3:0]  pend_c;

   assign b       = item.data_byte;
   assign shifted = {gather_ff[23:0], b};

   // next state: one byte of the segment walk
   always_comb begin
      phase_in    = phase_ff;
      gather_in   = gather_ff;
      gcnt_in     = gcnt_ff;
      marker_in   = marker_ff;
      tiff_pos_in = tiff_pos_ff;
      tiff_len_in = tiff_len_ff;
      le_in       = le_ff;
      dir_in      = dir_ff;
      entries_in  = entries_ff;
      tag_type_in = tag_type_ff;
      pend_in     = pend_ff;
      fix_en      = 1'b0;
      fix_val     = ORIENT_DEFAULT;

      len_word = {gather_ff[7:0], b};
      len_rem  = len_word - 16'd2;
      skip_rem = (seg_rem_ff != 16'd0) ? seg_rem_ff - 16'd1 : seg_rem_ff;
      off32    = order32(shifted, le_ff);
      gap_pos  = tiff_pos_ff + 16'd1;
      cnt_word = order16(shifted[15:0], le_ff);
      need     = {1'b0, cnt_word, 3'b000} + {2'b00, cnt_word, 2'b00} + 20'd2;
      avail    = tiff_len_ff - dir_ff;
      ent_dec  = entries_ff - 16'd1;
      val_word = order16(shifted[15:0], le_ff);

      // inside the Exif segment every byte counts down the segment length
      rem_dec = seg_rem_ff;
      if (phase_ff >= PH_EXIFHDR && phase_ff <= PH_WAIT && seg_rem_ff != 16'd0) begin
         rem_dec = seg_rem_ff - 16'd1;
      end
      seg_rem_in = rem_dec;

      unique case (phase_ff)
         PH_SOI0: begin
            if (b == MARKER_PREFIX) phase_in = PH_SOI1;
            else fix_en = 1'b1;
         end
         PH_SOI1: begin
            if (b == MARKER_SOI) phase_in = PH_MARK0;
            else fix_en = 1'b1;
         end
         PH_MARK0: begin
            if (b == MARKER_PREFIX) phase_in = PH_MARK1;
            else fix_en = 1'b1;
         end
         PH_MARK1: begin
            if (b == MARKER_SOS || b == MARKER_EOI) begin
               fix_en = 1'b1;
            end else begin
               marker_in = b;
               phase_in  = PH_LEN0;
            end
         end
         PH_LEN0: begin
            gather_in = {24'd0, b};
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            if (len_word < 16'd2) begin
               fix_en = 1'b1;
            end else begin
               seg_rem_in = len_rem;
               gcnt_in    = 4'd0;
               if (marker_ff == MARKER_APP1 && len_rem >= EXIF_HDR_LEN) begin
                  phase_in = PH_EXIFHDR;
               end else begin
                  phase_in = (len_rem == 16'd0) ? PH_MARK0 : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            seg_rem_in = skip_rem;
            if (skip_rem == 16'd0) phase_in = PH_MARK0;
         end
         PH_EXIFHDR: begin
            if (gcnt_ff >= 4'd6 || b != exif_sig(gcnt_ff[2:0])) begin
               // not an Exif header: skip the rest of the segment
               phase_in = (rem_dec == 16'd0) ? PH_MARK0 : PH_SKIP;
            end else begin
               gcnt_in = gcnt_ff + 4'd1;
               if (gcnt_ff == 4'd5) begin
                  tiff_len_in = rem_dec;
                  if (rem_dec < TIFF_MIN_LEN) begin
                     fix_en = 1'b1;
                  end else begin
                     tiff_pos_in = 16'd0;
                     gcnt_in     = 4'd0;
                     gather_in   = 32'd0;
                     phase_in    = PH_TIFFHDR;
                  end
               end
            end
         end
         PH_TIFFHDR: begin
            gather_in   = shifted;
            tiff_pos_in = tiff_pos_ff + 16'd1;
            if (tiff_pos_ff == 16'd1) begin
               // byte order mark
               if (gather_ff[7:0] == CHAR_I && b == CHAR_I) le_in = 1'b1;
               else if (gather_ff[7:0] == CHAR_M && b == CHAR_M) le_in = 1'b0;
               else fix_en = 1'b1;
               gather_in = 32'd0;
            end else if (tiff_pos_ff == 16'd3) begin
               if (order16(shifted[15:0], le_ff) != TIFF_MAGIC) fix_en = 1'b1;
               gather_in = 32'd0;
            end else if (tiff_pos_ff == 16'd7) begin
               // first directory offset: past the header, room for the count
               if (off32 < {16'd0, TIFF_MIN_LEN} || off32 >= {16'd0, tiff_len_ff} ||
                   (tiff_len_ff - off32[15:0]) < 16'd2) begin
                  fix_en = 1'b1;
               end else begin
                  dir_in    = off32[15:0];
                  gather_in = 32'd0;
                  gcnt_in   = 4'd0;
                  phase_in  = (off32[15:0] == TIFF_MIN_LEN) ? PH_COUNT : PH_GAP;
               end
            end
         end
         PH_GAP: begin
            tiff_pos_in = gap_pos;
            if (gap_pos >= dir_ff) phase_in = PH_COUNT;
         end
         PH_COUNT: begin
            gather_in = shifted;
            gcnt_in   = gcnt_ff + 4'd1;
            if (gcnt_ff >= 4'd1) begin
               // entry table must fit inside the TIFF area
               if (cnt_word == 16'd0 || need > {4'd0, avail}) begin
                  fix_en = 1'b1;
               end else begin
                  entries_in  = cnt_word;
                  gcnt_in     = 4'd0;
                  gather_in   = 32'd0;
                  tag_type_in = 32'd0;
                  phase_in    = PH_ENTRY;
               end
            end
         end
         PH_ENTRY: begin
            if (gcnt_ff < 4'd4) tag_type_in = {tag_type_ff[23:0], b};
            else if (gcnt_ff < 4'd8) gather_in = shifted;
            if (gcnt_ff == 4'd7 &&
                order16(tag_type_ff[31:16], le_ff) == TAG_ORIENTATION &&
                order16(tag_type_ff[15:0], le_ff) == TYPE_SHORT &&
                off32 == 32'd1) begin
               // orientation entry: value field follows
               gcnt_in   = 4'd0;
               gather_in = 32'd0;
               phase_in  = PH_VALUE;
            end else begin
               gcnt_in = gcnt_ff + 4'd1;
               if (gcnt_ff >= ENTRY_LAST_IDX) begin
                  entries_in = ent_dec;
                  if (ent_dec == 16'd0) begin
                     fix_en = 1'b1;
                  end else begin
                     gcnt_in     = 4'd0;
                     gather_in   = 32'd0;
                     tag_type_in = 32'd0;
                  end
               end
            end
         end
         PH_VALUE: begin
            gather_in = shifted;
            gcnt_in   = gcnt_ff + 4'd1;
            if (gcnt_ff >= 4'd1) begin
               if (val_word < 16'd1 || val_word > 16'd8) begin
                  fix_en = 1'b1;
               end else begin
                  pend_in = val_word[3:0];
                  if (rem_dec == 16'd0) begin
                     fix_en  = 1'b1;
                     fix_val = val_word[3:0];
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
            end
         end
         PH_WAIT: begin
            // value stands once the whole segment has arrived
            if (rem_dec == 16'd0) begin
               fix_en  = 1'b1;
               fix_val = pend_ff;
            end
         end
         PH_DONE: begin
            seg_rem_in = seg_rem_ff;
         end
         default: begin
            fix_en = 1'b1;
         end
      endcase

      if (fix_en) begin
         phase_in = PH_DONE;
         pend_in  = fix_val;
      end

      done_c = (phase_in == PH_DONE);
      pend_c = pend_in;

      // last byte closes the buffer: back to the start for the next one
      if (item.last_byte) begin
         phase_in    = PH_SOI0;
         gather_in   = 32'd0;
         gcnt_in     = 4'd0;
         seg_rem_in  = 16'd0;
         marker_in   = 8'd0;
         tiff_pos_in = 16'd0;
         tiff_len_in = 16'd0;
         le_in       = 1'b0;
         dir_in      = 16'd0;
         entries_in  = 16'd0;
         tag_type_in = 32'd0;
         pend_in     = ORIENT_DEFAULT;
      end
   end

   // outputs: answer for a buffer closed by this byte
   always_comb begin
      answer = done_c ? pend_c : ORIENT_DEFAULT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SOI0;
         gather_ff   <= 32'd0;
         gcnt_ff     <= 4'd0;
         seg_rem_ff  <= 16'd0;
         marker_ff   <= 8'd0;
         tiff_pos_ff <= 16'd0;
         tiff_len_ff <= 16'd0;
         le_ff       <= 1'b0;
         dir_ff      <= 16'd0;
         entries_ff  <= 16'd0;
         tag_type_ff <= 32'd0;
         pend_ff     <= ORIENT_DEFAULT;
      end else if (step) begin
         phase_ff    <= phase_in;
         gather_ff   <= gather_in;
         gcnt_ff     <= gcnt_in;
         seg_rem_ff  <= seg_rem_in;
         marker_ff   <= marker_in;
         tiff_pos_ff <= tiff_pos_in;
         tiff_len_ff <= tiff_len_in;
         le_ff       <= le_in;
         dir_ff      <= dir_in;
         entries_ff  <= entries_in;
         tag_type_ff <= tag_type_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

`default_nettype wire
